### rtl/gwms_pkg.sv
// ----------------------------------------------------------------------------
// gwms_pkg
// Shared types and constants for the gaussian window matrix smoother.
// ----------------------------------------------------------------------------
package gwms_pkg;

  localparam int NENT    = 9;
  localparam int DATA_W  = 32;
  localparam int ACC_W   = 64;
  localparam int MAXRES  = 32;
  localparam int NRES_W  = 5;
  localparam int STEP_W  = 5;
  localparam int CFG_W   = 7;
  localparam int WIN_RST = 30;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef logic [NENT-1:0][DATA_W-1:0] mat_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
    logic abs_en;
    logic add_en;
    logic init_en;
    logic step_en;
    logic fin_en;
  } lane_ctrl_t;

endpackage

### rtl/gaussian_window_matrix_smoother_core.sv
// ----------------------------------------------------------------------------
// gaussian_window_matrix_smoother_core
// Weighted window average over a stream of 3x3 matrices.
// ----------------------------------------------------------------------------
// One transaction at a time. Weight loads, pushes with no result and flushes
// with nothing to emit are taken in S_IDLE and leave it idle. Each result goes
// through a start state, the held matrices read from the store one row per
// cycle (all nine entries multiplied in parallel), a drain state, the ABS, ADD
// and INIT states to take the magnitude and set up the division, then each
// entry divided by the weight sum one quotient bit per cycle, a saturation
// state and the output state; the result waits there for out_ready. A flush
// gives up to 32 results, the last marked by last. Memories need no clearing
// after reset.
module gaussian_window_matrix_smoother_core #(
  parameter int MAX_WINDOW = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [5:0]  weight_index,
  input  logic [17:0] weight_value,
  input  logic [31:0] m00,
  input  logic [31:0] m01,
  input  logic [31:0] m02,
  input  logic [31:0] m10,
  input  logic [31:0] m11,
  input  logic [31:0] m12,
  input  logic [31:0] m20,
  input  logic [31:0] m21,
  input  logic [31:0] m22,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] s00,
  output logic [31:0] s01,
  output logic [31:0] s02,
  output logic [31:0] s10,
  output logic [31:0] s11,
  output logic [31:0] s12,
  output logic [31:0] s20,
  output logic [31:0] s21,
  output logic [31:0] s22,
  output logic        last
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int FW = $clog2(MAX_WINDOW + 1);
  localparam int WW = FRAC_BITS + 2;
  localparam int SW = WW + FW;
  localparam int NE = gwms_pkg::NENT;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_READ, S_DRAIN, S_ABS, S_ADD, S_INIT, S_STEP, S_FIN, S_OUT
  } state_t;

  state_t                       state;
  logic [gwms_pkg::CFG_W-1:0]   window_length;
  logic [FW-1:0]                fill;
  logic [AW-1:0]                oldest;
  logic [AW-1:0]                rd_slot;
  logic [AW-1:0]                w_addr;
  logic [AW-1:0]                emit_off;
  logic [FW-1:0]                j;
  logic                         d1;
  logic                         d2;
  logic [WW-1:0]                w_q;
  logic [SW-1:0]                wsum;
  logic [gwms_pkg::STEP_W-1:0]  step;
  logic [gwms_pkg::NRES_W-1:0]  nres;
  logic                         mode_flush;
  logic                         drop_after;

  logic [FW-1:0]                k;
  logic [FW-1:0]                khalf;
  logic                         full;
  logic [AW-1:0]                o1;
  logic [FW-1:0]                f1;
  logic [FW-1:0]                f2;
  logic [FW:0]                  slot_sum;
  logic [AW-1:0]                wr_slot;
  logic                         acc_in;
  gwms_pkg::mat_t               in_mat;
  gwms_pkg::mat_t               st_rdata;
  logic [WW-1:0]                wt_rdata;
  logic                         wt_we;
  gwms_pkg::lane_ctrl_t         ctrl;
  logic [NE-1:0][31:0]          res;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign acc_in    = in_valid && in_ready;

  always_comb begin
    if (window_length < 7'd2) begin
      k = FW'(2);
    end else if (32'(window_length) > MAX_WINDOW) begin
      k = FW'(MAX_WINDOW);
    end else begin
      k = FW'(window_length);
    end
  end
  assign khalf = k >> 1;

  assign full     = (fill == FW'(MAX_WINDOW));
  assign o1       = full ? inc(oldest) : oldest;
  assign f1       = full ? fill - 1'b1 : fill;
  assign f2       = f1 + 1'b1;
  assign slot_sum = (FW+1)'(o1) + (FW+1)'(f1);
  assign wr_slot  = (32'(slot_sum) >= MAX_WINDOW) ? AW'(slot_sum - (FW+1)'(MAX_WINDOW))
                                                  : AW'(slot_sum);

  assign in_mat = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
  assign wt_we  = acc_in && (cmd == gwms_pkg::CMD_LOAD) && (32'(weight_index) < MAX_WINDOW);

  gwms_store #(.DEPTH(MAX_WINDOW), .AW(AW)) u_store (
    .clk   (clk),
    .we    (acc_in && (cmd == gwms_pkg::CMD_PUSH)),
    .waddr (wr_slot),
    .wdata (in_mat),
    .raddr (rd_slot),
    .rdata (st_rdata)
  );

  gwms_weights #(.DEPTH(MAX_WINDOW), .AW(AW), .WW(WW)) u_weights (
    .clk   (clk),
    .we    (wt_we),
    .waddr (AW'(weight_index)),
    .wdata (WW'(weight_value)),
    .raddr (w_addr),
    .rdata (wt_rdata)
  );

  always_comb begin
    ctrl         = '0;
    ctrl.clr     = (state == S_START);
    ctrl.mul_en  = d1;
    ctrl.acc_en  = d2;
    ctrl.abs_en  = (state == S_ABS);
    ctrl.add_en  = (state == S_ADD);
    ctrl.init_en = (state == S_INIT);
    ctrl.step_en = (state == S_STEP);
    ctrl.fin_en  = (state == S_FIN);
  end

  for (genvar e = 0; e < NE; e++) begin : g_lane
    gwms_lane #(.WW(WW), .SW(SW)) u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .w    (wt_rdata),
      .v    (st_rdata[e]),
      .wsum (wsum),
      .res  (res[e])
    );
  end

  assign s00 = res[0];
  assign s01 = res[1];
  assign s02 = res[2];
  assign s10 = res[3];
  assign s11 = res[4];
  assign s12 = res[5];
  assign s20 = res[6];
  assign s21 = res[7];
  assign s22 = res[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= gwms_pkg::CFG_W'(gwms_pkg::WIN_RST);
      fill          <= '0;
      oldest        <= '0;
      d1            <= 1'b0;
      d2            <= 1'b0;
      last          <= 1'b0;
      mode_flush    <= 1'b0;
      drop_after    <= 1'b0;
      nres          <= '0;
    end else begin
      d1 <= (state == S_READ);
      d2 <= d1;
      if (d1) begin
        w_q <= wt_rdata;
      end
      if (state == S_START) begin
        wsum <= '0;
      end else if (d2) begin
        wsum <= wsum + SW'(w_q);
      end
      if (cfg_valid && cfg_ready) begin
        window_length <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            case (gwms_pkg::cmd_t'(cmd))
              gwms_pkg::CMD_PUSH: begin
                oldest     <= o1;
                fill       <= f2;
                mode_flush <= 1'b0;
                if (f2 < k) begin
                  drop_after <= 1'b0;
                  emit_off   <= AW'(k - f2);
                  if (f2 >= khalf) begin
                    state <= S_START;
                  end
                end else begin
                  drop_after <= 1'b1;
                  emit_off   <= '0;
                  state      <= S_START;
                end
              end
              gwms_pkg::CMD_FLUSH: begin
                mode_flush <= 1'b1;
                emit_off   <= '0;
                nres       <= '0;
                if (fill > khalf) begin
                  state <= S_START;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_START: begin
          rd_slot <= oldest;
          w_addr  <= emit_off;
          j       <= '0;
          state   <= S_READ;
        end
        S_READ: begin
          rd_slot <= inc(rd_slot);
          w_addr  <= w_addr + 1'b1;
          j       <= j + 1'b1;
          if (j == fill - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!d1 && !d2) begin
            state <= S_ABS;
          end
        end
        S_ABS: begin
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_INIT;
        end
        S_INIT: begin
          step  <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          step <= step + 1'b1;
          if (step == '1) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          last  <= !mode_flush || (fill - 1'b1 <= khalf) ||
                   (nres == gwms_pkg::NRES_W'(gwms_pkg::MAXRES - 1));
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (!mode_flush) begin
              if (drop_after) begin
                oldest <= inc(oldest);
                fill   <= fill - 1'b1;
              end
              state <= S_IDLE;
            end else begin
              oldest <= inc(oldest);
              fill   <= fill - 1'b1;
              nres   <= nres + 1'b1;
              state  <= last ? S_IDLE : S_START;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/gwms_store.sv
// ----------------------------------------------------------------------------
// gwms_store
// Circular matrix store, one matrix per row, registered read.
// ----------------------------------------------------------------------------
module gwms_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  gwms_pkg::mat_t  wdata,
  input  logic [AW-1:0]   raddr,
  output gwms_pkg::mat_t  rdata
);

  gwms_pkg::mat_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/gwms_weights.sv
// ----------------------------------------------------------------------------
// gwms_weights
// Weight table memory, registered read.
// ----------------------------------------------------------------------------
module gwms_weights #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WW    = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [WW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [WW-1:0] rdata
);

  logic [WW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/gwms_lane.sv
// ----------------------------------------------------------------------------
// gwms_lane
// One matrix entry: weighted accumulate, rounded restoring divide by the
// weight sum, saturation to 32 bits.
// ----------------------------------------------------------------------------
module gwms_lane #(
  parameter int WW = 18,
  parameter int SW = 25
) (
  input  logic                        clk,
  input  gwms_pkg::lane_ctrl_t        ctrl,
  input  logic [WW-1:0]               w,
  input  logic [gwms_pkg::DATA_W-1:0] v,
  input  logic [SW-1:0]               wsum,
  output logic [gwms_pkg::DATA_W-1:0] res
);

  localparam int DW = gwms_pkg::DATA_W;
  localparam int AC = gwms_pkg::ACC_W;
  localparam int PW = WW + 1 + DW;
  localparam int CW = (SW > DW) ? SW : DW;

  logic signed [PW-1:0] prod;
  logic [AC-1:0]        acc;
  logic                 neg;
  logic [AC-1:0]        mag;
  logic [AC-1:0]        dd;
  logic                 ovf;
  logic [SW-1:0]        rem;
  logic [DW-1:0]        dlo;
  logic [DW-1:0]        q;
  logic [SW:0]          sh;
  logic [SW:0]          dif;
  logic                 ge;

  assign sh  = {rem, dlo[DW-1]};
  assign ge  = sh >= {1'b0, wsum};
  assign dif = sh - {1'b0, wsum};

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= $signed({1'b0, w}) * $signed(v);
    end
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + AC'(prod);
    end
    if (ctrl.abs_en) begin
      neg <= acc[AC-1];
      mag <= acc[AC-1] ? (AC'(0) - acc) : acc;
    end
    if (ctrl.add_en) begin
      dd <= mag + AC'(wsum >> 1);
    end
    if (ctrl.init_en) begin
      ovf <= CW'(dd[AC-1:DW]) >= CW'(wsum);
      rem <= SW'(dd[AC-1:DW]);
      dlo <= dd[DW-1:0];
      q   <= '0;
    end else if (ctrl.step_en) begin
      rem <= ge ? SW'(dif) : SW'(sh);
      q   <= {q[DW-2:0], ge};
      dlo <= {dlo[DW-2:0], 1'b0};
    end
    if (ctrl.fin_en) begin
      if (wsum == '0) begin
        res <= '0;
      end else if (neg) begin
        res <= (ovf || q > {1'b1, {(DW-1){1'b0}}}) ? {1'b1, {(DW-1){1'b0}}}
                                                   : DW'(0) - q;
      end else begin
        res <= (ovf || q[DW-1]) ? {1'b0, {(DW-1){1'b1}}} : q;
      end
    end
  end

endmodule
